>>> src/msd_pkg.sv
package msd_pkg;

   localparam int MAX_CODE_LEN = 6;
   localparam int CODE_W = 6;
   localparam int LEN_W = 3;
   localparam int CHAR_W = 7;
   localparam int SYM_W = 3;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W = 2;
   localparam int CNT_W = 3;

   localparam logic [SYM_W-1:0] SYM_DOT = 3'd0;
   localparam logic [SYM_W-1:0] SYM_DASH = 3'd1;
   localparam logic [SYM_W-1:0] SYM_SPACE = 3'd2;
   localparam logic [SYM_W-1:0] SYM_END = 3'd3;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0a;
   localparam logic [CHAR_W-1:0] UNKNOWN_RESET = 7'h6e;

   typedef struct packed {
      logic [CODE_W-1:0] pattern;
      logic [LEN_W-1:0]  length;
      logic              invalid;
      logic              after_space;
      logic              gap_pending;
   } dec_state_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } result_type;

   typedef struct packed {
      logic              hit;
      logic [CHAR_W-1:0] ch;
   } lookup_type;

   // The pattern holds the first element in its most significant used bit, dash as one.
   function automatic lookup_type lookup_code(input logic [LEN_W-1:0] len,
                                              input logic [CODE_W-1:0] pat);
      lookup_type res;
      res = '{hit: 1'b1, ch: 7'h00};
      unique case ({len, pat})
         {3'd2, 6'd1}:  res.ch = 7'h61;
         {3'd4, 6'd8}:  res.ch = 7'h62;
         {3'd4, 6'd10}: res.ch = 7'h63;
         {3'd3, 6'd4}:  res.ch = 7'h64;
         {3'd1, 6'd0}:  res.ch = 7'h65;
         {3'd4, 6'd2}:  res.ch = 7'h66;
         {3'd3, 6'd6}:  res.ch = 7'h67;
         {3'd4, 6'd0}:  res.ch = 7'h68;
         {3'd2, 6'd0}:  res.ch = 7'h69;
         {3'd4, 6'd7}:  res.ch = 7'h6a;
         {3'd3, 6'd5}:  res.ch = 7'h6b;
         {3'd4, 6'd4}:  res.ch = 7'h6c;
         {3'd2, 6'd3}:  res.ch = 7'h6d;
         {3'd2, 6'd2}:  res.ch = 7'h6e;
         {3'd3, 6'd7}:  res.ch = 7'h6f;
         {3'd4, 6'd6}:  res.ch = 7'h70;
         {3'd4, 6'd13}: res.ch = 7'h71;
         {3'd3, 6'd2}:  res.ch = 7'h72;
         {3'd3, 6'd0}:  res.ch = 7'h73;
         {3'd1, 6'd1}:  res.ch = 7'h74;
         {3'd3, 6'd1}:  res.ch = 7'h75;
         {3'd4, 6'd1}:  res.ch = 7'h76;
         {3'd3, 6'd3}:  res.ch = 7'h77;
         {3'd4, 6'd9}:  res.ch = 7'h78;
         {3'd4, 6'd11}: res.ch = 7'h79;
         {3'd4, 6'd12}: res.ch = 7'h7a;
         {3'd5, 6'd31}: res.ch = 7'h30;
         {3'd5, 6'd15}: res.ch = 7'h31;
         {3'd5, 6'd7}:  res.ch = 7'h32;
         {3'd5, 6'd3}:  res.ch = 7'h33;
         {3'd5, 6'd1}:  res.ch = 7'h34;
         {3'd5, 6'd0}:  res.ch = 7'h35;
         {3'd5, 6'd16}: res.ch = 7'h36;
         {3'd5, 6'd24}: res.ch = 7'h37;
         {3'd5, 6'd28}: res.ch = 7'h38;
         {3'd5, 6'd30}: res.ch = 7'h39;
         {3'd6, 6'd21}: res.ch = 7'h2e;
         {3'd6, 6'd51}: res.ch = 7'h2c;
         {3'd6, 6'd12}: res.ch = 7'h3f;
         {3'd6, 6'd43}: res.ch = 7'h21;
         default:       res.hit = 1'b0;
      endcase
      return res;
   endfunction

endpackage

>>> src/morse_symbol_stream_decoder.sv
// Decodes a stream of Morse symbols into ASCII characters. Each req transfer carries one
// symbol (dot, dash, space, end of message, anything else counts as a foreign character);
// each rsp transfer carries one character, with tlast set on the newline that closes a
// message after a word gap. A single space emits the gathered code as a letter, digit or
// punctuation mark, or as the csr-programmed unknown character; a second space marks a word
// gap that is emitted as a space in front of the next symbol, or as a newline on an end.
// The decoder state sits in a one-entry synchronous memory that is read every cycle, with
// the last written value forwarded, so a symbol is taken in every ready cycle. Results go
// through a four-entry queue; the input is ready while at least two entries are free, so
// with rsp_tready held high the block takes one symbol per cycle without a stall. A pending
// word gap always follows a closed code, so no symbol gives more than one character.
module morse_symbol_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [2:0] symbol, [7:3] zero
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [msd_pkg::CHAR_W-1:0] csr_data
);
   import msd_pkg::*;

   logic [CHAR_W-1:0] unknown_ff;

   dec_state_type state_mem [0:0];
   dec_state_type state_rd_ff;
   dec_state_type fwd_ff;
   logic          fwd_last_ff;
   logic          state_valid_ff;
   dec_state_type state_cur;
   dec_state_type state_in;

   result_type fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   logic             req_xfer;
   logic             rsp_xfer;
   logic [SYM_W-1:0] sym;
   lookup_type       lk;
   logic [CHAR_W-1:0] code_char;
   result_type       r0, r1, slot0;
   logic             v0, v1;
   logic [1:0]       n_push;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         unknown_ff <= UNKNOWN_RESET;
      end else if (csr_valid) begin
         unknown_ff <= csr_data;
      end
   end

   assign sym = req_tdata[SYM_W-1:0];
   assign req_tready = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // State memory: read every cycle, the entry written at the previous edge is forwarded.
   always_ff @(posedge clock) begin
      state_rd_ff <= state_mem[0];
      if (req_xfer) begin
         state_mem[0] <= state_in;
         fwd_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_last_ff <= 1'b0;
         state_valid_ff <= 1'b0;
      end else begin
         fwd_last_ff <= req_xfer;
         if (req_xfer) begin
            state_valid_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      if (!state_valid_ff) begin
         state_cur = '0;
      end else if (fwd_last_ff) begin
         state_cur = fwd_ff;
      end else begin
         state_cur = state_rd_ff;
      end
   end

   always_comb begin
      state_in = state_cur;
      v0 = 1'b0;
      v1 = 1'b0;
      lk = lookup_code(state_cur.length, state_cur.pattern);
      code_char = (state_cur.invalid || !lk.hit) ? unknown_ff : lk.ch;
      r0 = '{ch: code_char, last: 1'b0};
      r1 = '{ch: CHAR_NEWLINE, last: 1'b1};
      unique case (sym)
         SYM_SPACE: begin
            if (!state_cur.after_space) begin
               v0 = 1'b1;
               state_in.pattern = '0;
               state_in.length = '0;
               state_in.invalid = 1'b0;
               state_in.after_space = 1'b1;
            end else begin
               r0 = '{ch: CHAR_SPACE, last: 1'b0};
               v0 = state_cur.gap_pending;
               state_in.gap_pending = 1'b1;
            end
         end
         SYM_END: begin
            v0 = (state_cur.length != '0) || state_cur.invalid;
            v1 = state_cur.gap_pending;
            state_in = '0;
         end
         default: begin
            r0 = '{ch: CHAR_SPACE, last: 1'b0};
            v0 = state_cur.gap_pending;
            state_in.gap_pending = 1'b0;
            state_in.after_space = 1'b0;
            if ((sym == SYM_DOT || sym == SYM_DASH)
                && state_cur.length < LEN_W'(MAX_CODE_LEN)) begin
               state_in.pattern = {state_cur.pattern[CODE_W-2:0], sym[0]};
               state_in.length = state_cur.length + 1'b1;
            end else begin
               state_in.invalid = 1'b1;
            end
         end
      endcase
      slot0 = v0 ? r0 : r1;
      n_push = {1'b0, v0} + {1'b0, v1};
   end

   always_ff @(posedge clock) begin
      if (req_xfer && n_push != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= slot0;
      end
      if (req_xfer && n_push == 2'd2) begin
         fifo_ff[wr_ptr_ff + 1'b1] <= r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (req_xfer) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(n_push);
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (req_xfer ? CNT_W'(n_push) : '0)
                     - CNT_W'(rsp_xfer);
      end
   end

   assign rsp_tdata = {1'b0, fifo_ff[rd_ptr_ff].ch};
   assign rsp_tlast = fifo_ff[rd_ptr_ff].last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_xfer && sym == SYM_END |=> state_cur == '0)
      else $error("end of message did not clear the decoder state");

   a_space_marks: assert property (@(posedge clock) disable iff (reset)
      req_xfer && sym == SYM_SPACE |=> state_cur.after_space && state_cur.length == '0)
      else $error("space did not close the code");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(req_xfer) && !$past(rsp_xfer) |-> $stable(count_ff))
      else $error("queue count moved without a transfer");

endmodule

>>> verif/morse_symbol_stream_decoder_tb.sv
module morse_symbol_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_SYMBOLS = 475;
   localparam logic [2:0] SYM_OTHER = 3'd4;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } decoded_char_type;

   class char_scoreboard;
      string morse_codes[40] = '{
         ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
         "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
         "..-", "...-", ".--", "-..-", "-.--", "--..", "-----", ".----", "..---",
         "...--", "....-", ".....", "-....", "--...", "---..", "----.", ".-.-.-",
         "--..--", "..--..", "-.-.--"};
      string glyphs = "abcdefghijklmnopqrstuvwxyz0123456789.,?!";

      logic [6:0] unknown_char = msd_pkg::UNKNOWN_RESET;
      logic [5:0] code_bits = '0;
      logic [2:0] code_len = '0;
      logic       code_bad = 1'b0;
      logic       after_space = 1'b0;
      logic       gap_pending = 1'b0;

      decoded_char_type pending_chars[$];
      int symbols_seen = 0;
      int chars_checked = 0;
      int newlines_seen = 0;
      int failures = 0;

      function void set_unknown(logic [6:0] value);
         unknown_char = value;
      endfunction

      function int pending_count();
         return pending_chars.size();
      endfunction

      function void clear_code();
         code_bits = '0;
         code_len = '0;
         code_bad = 1'b0;
      endfunction

      function void push_char(logic [6:0] ch, logic last);
         decoded_char_type item;
         item.ch = ch;
         item.last = last;
         pending_chars.push_back(item);
      endfunction

      function logic [6:0] current_char();
         string txt = "";
         if (code_bad) return unknown_char;
         for (int i = int'(code_len) - 1; i >= 0; i--) begin
            if (code_bits[i]) txt = {txt, "-"};
            else txt = {txt, "."};
         end
         foreach (morse_codes[k]) begin
            if (morse_codes[k] == txt) return 7'(glyphs.getc(k));
         end
         return unknown_char;
      endfunction

      function void note_symbol(logic [2:0] sym);
         symbols_seen++;
         if (sym == msd_pkg::SYM_SPACE) begin
            if (!after_space) begin
               push_char(current_char(), 1'b0);
               clear_code();
               after_space = 1'b1;
            end else begin
               if (gap_pending) push_char(msd_pkg::CHAR_SPACE, 1'b0);
               gap_pending = 1'b1;
            end
         end else if (sym == msd_pkg::SYM_END) begin
            if (code_len != 0 || code_bad) push_char(current_char(), 1'b0);
            if (gap_pending) push_char(msd_pkg::CHAR_NEWLINE, 1'b1);
            clear_code();
            after_space = 1'b0;
            gap_pending = 1'b0;
         end else begin
            if (gap_pending) begin
               push_char(msd_pkg::CHAR_SPACE, 1'b0);
               gap_pending = 1'b0;
            end
            after_space = 1'b0;
            if (sym == msd_pkg::SYM_DOT || sym == msd_pkg::SYM_DASH) begin
               if (code_len < msd_pkg::MAX_CODE_LEN) begin
                  code_bits = {code_bits[4:0], sym[0]};
                  code_len++;
               end else begin
                  code_bad = 1'b1;
               end
            end else begin
               code_bad = 1'b1;
            end
         end
      endfunction

      function void check_char(logic [7:0] data, logic last);
         decoded_char_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected char %h last %b with nothing pending", $time, data, last);
            failures++;
            return;
         end
         want = pending_chars.pop_front();
         chars_checked++;
         if (last) newlines_seen++;
         if (data !== {1'b0, want.ch} || last !== want.last) begin
            $display("%0t: expected char %h last %b, got char %h last %b",
                     $time, {1'b0, want.ch}, want.last, data, last);
            failures++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [msd_pkg::CHAR_W-1:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles = 0;
   char_scoreboard board = new;

   morse_symbol_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_char(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d chars still pending",
                  $time, idle_cycles, board.pending_count());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   // The valid stays high on return so that back-to-back symbols need no second assignment.
   task automatic send_symbol(input logic [2:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, sym};
      do @(posedge clock); while (!req_tready);
      board.note_symbol(sym);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_unknown(input logic [6:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_unknown(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_message();
      int  words;
      int  letters;
      int  elems;
      bit  open_tail;
      words = $urandom_range(1, 4);
      open_tail = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) send_symbol(msd_pkg::SYM_SPACE);
      for (int w = 0; w < words; w++) begin
         letters = $urandom_range(1, 5);
         for (int l = 0; l < letters; l++) begin
            if ($urandom_range(19) == 0) begin
               repeat ($urandom_range(1, 4)) send_symbol(3'($urandom_range(7)));
            end else begin
               if ($urandom_range(15) == 0) elems = $urandom_range(7, 8);
               else elems = $urandom_range(1, msd_pkg::MAX_CODE_LEN);
               for (int e = 0; e < elems; e++) begin
                  if ($urandom_range(31) == 0)
                     send_symbol(SYM_OTHER | 3'($urandom_range(3)));
                  else if ($urandom_range(1))
                     send_symbol(msd_pkg::SYM_DASH);
                  else
                     send_symbol(msd_pkg::SYM_DOT);
               end
            end
            if (!(open_tail && w == words - 1 && l == letters - 1))
               send_symbol(msd_pkg::SYM_SPACE);
         end
         if (w < words - 1 || (!open_tail && $urandom_range(3) != 0)) begin
            if ($urandom_range(3) == 0) repeat ($urandom_range(2, 3)) send_symbol(msd_pkg::SYM_SPACE);
            else send_symbol(msd_pkg::SYM_SPACE);
         end
      end
      if ($urandom_range(7) != 0) send_symbol(msd_pkg::SYM_END);
   endtask

   task automatic run_phase(input int count);
      int first;
      bit paused;
      first = board.symbols_seen;
      paused = 1'b0;
      while (board.symbols_seen - first < count) begin
         send_message();
         if (!paused && board.symbols_seen - first >= count / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   task automatic send_opening();
      logic [2:0] opening[$] = '{
         msd_pkg::SYM_SPACE,
         msd_pkg::SYM_DOT, msd_pkg::SYM_SPACE,
         msd_pkg::SYM_DASH, msd_pkg::SYM_DOT, msd_pkg::SYM_DASH, msd_pkg::SYM_DOT,
         msd_pkg::SYM_DASH, msd_pkg::SYM_DASH, msd_pkg::SYM_SPACE,
         msd_pkg::SYM_SPACE, msd_pkg::SYM_SPACE,
         msd_pkg::SYM_DOT, msd_pkg::SYM_DOT, msd_pkg::SYM_DOT, msd_pkg::SYM_DOT,
         msd_pkg::SYM_DOT, msd_pkg::SYM_DOT, msd_pkg::SYM_DOT,
         msd_pkg::SYM_SPACE, msd_pkg::SYM_SPACE, msd_pkg::SYM_END,
         msd_pkg::SYM_DASH, SYM_OTHER | 3'd3, msd_pkg::SYM_END, msd_pkg::SYM_END};
      foreach (opening[i]) send_symbol(opening[i]);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 31;
      recv_idle_pct = 61;
      send_opening();
      drain_results();
      write_unknown(7'd0);
      run_phase(PHASE_SYMBOLS);

      drain_results();
      send_idle_pct = 61;
      recv_idle_pct = 31;
      write_unknown(7'd127);
      run_phase(PHASE_SYMBOLS);

      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_unknown(7'($urandom_range(1, 126)));
      run_phase(PHASE_SYMBOLS);

      drain_results();
      if (board.pending_count() != 0) begin
         $display("%0t: %0d expected chars never arrived", $time, board.pending_count());
         board.failures++;
      end
      $display("Sent %0d symbols and checked %0d decoded chars, %0d of them message ends.",
               board.symbols_seen, board.chars_checked, board.newlines_seen);
      $display("Unknown char was default, zero, all ones and random, under three stall mixes.");
      if (board.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

>>> files.f
src/msd_pkg.sv
src/morse_symbol_stream_decoder.sv
verif/morse_symbol_stream_decoder_tb.sv
